// ===== rtl/core/lzw_compressor_12bit_assert.svh =====
// Assertion macros shared by the compressor modules.
`ifndef LZW_COMPRESSOR_12BIT_ASSERT_SVH
`define LZW_COMPRESSOR_12BIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LZW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LZW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LZW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LZW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lzw_pkg.sv =====
// Package with payload types and constants of the LZW compressor.
package lzw_pkg;
    localparam int unsigned CODE_BITS_DEF     = 12;
    localparam int unsigned TABLE_ENTRIES_DEF = 4095;
    localparam int unsigned FIRST_CODE        = 256;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // Request from the control sequencer to the bit packer.
    // A tail request is the final code of a stream; a flush request may follow it.
    typedef struct packed {
        logic        valid;
        logic        flush;
        logic        last;
        logic        tail;
        logic [15:0] code;
    } t_pack_req;
endpackage

// ===== rtl/core/lzw_compressor_12bit.sv =====
// LZW compressor top level: dictionary memory, search sequencer and packer.
// Throughput: a data byte is searched one dictionary entry per cycle, so the time before
// a code reaches the packer grows with the n learned entries (n is at most 3838); codes
// then leave one byte per cycle while i_ready is high; the dictionary read loop sets the rate.
// Reset (synchronous, active low) gives 256 entries, no open prefix and an
// empty bit buffer; the dictionary needs no clearing since only written entries are read.
`include "lzw_compressor_12bit_assert.svh"
module lzw_compressor_12bit #(
    parameter int unsigned CODE_BITS     = lzw_pkg::CODE_BITS_DEF,
    parameter int unsigned TABLE_ENTRIES = lzw_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lzw_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output lzw_pkg::t_out_item o_item
);
    import lzw_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned CW = IW + 1;
    localparam logic [CW-1:0] TE = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_CHECK, S_EMIT_MISS, S_EMIT_CUR, S_EMIT_CLR,
        S_END_CODE, S_END_FLUSH
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic [15:0]      r_prefix;
    logic             r_pvalid;
    logic [7:0]       r_byte;
    logic             r_rd_valid;
    logic [IW+7:0]    r_rd_data;
    logic [IW+7:0]    dict [0:(1<<IW)-1];
    t_pack_req        req;
    logic             pk_busy, pk_pending;
    logic [IW+7:0]    key;

    assign key     = {r_prefix[IW-1:0], r_byte};
    assign o_ready = (r_state == S_IDLE) && !pk_busy && !req.valid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEARCH && r_idx < r_count) begin
            r_rd_data <= dict[r_idx[IW-1:0]];
        end
        if (r_state == S_CHECK && !r_rd_valid && r_count <= TE) begin
            dict[r_count[IW-1:0]] <= key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= CW'(FIRST_CODE); r_prefix <= '0;
            r_pvalid <= 1'b0; req <= '0; r_rd_valid <= 1'b0; r_idx <= '0;
        end else begin
            if (req.valid) req.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_byte <= i_item.byte_value;
                        if (i_item.command == CMD_END) begin
                            r_state <= S_END_CODE;
                        end else if (!r_pvalid) begin
                            r_prefix <= 16'(i_item.byte_value);
                            r_pvalid <= 1'b1;
                        end else begin
                            r_idx <= CW'(FIRST_CODE);
                            r_rd_valid <= 1'b0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // Compare last cycle's read while the next address is read.
                    if (r_rd_valid && r_rd_data == key) begin
                        r_prefix <= 16'(r_idx - CW'(1));
                        r_state <= S_CHECK;
                    end else if (r_idx >= r_count || r_idx > TE) begin
                        r_rd_valid <= 1'b0;
                        r_state <= S_CHECK;
                    end else begin
                        r_rd_valid <= 1'b1;
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_CHECK: begin
                    if (!r_rd_valid) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_EMIT_MISS;
                    end else if (r_count >= TE) begin
                        r_state <= S_EMIT_CUR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    r_rd_valid <= 1'b0;
                end
                S_EMIT_MISS: begin
                    if (!pk_busy && !req.valid) begin
                        req <= '{valid: 1'b1, flush: 1'b0, last: (r_count < TE),
                                 tail: 1'b0, code: r_prefix};
                        r_prefix <= 16'(r_byte);
                        r_state <= (r_count >= TE) ? S_EMIT_CUR : S_IDLE;
                    end
                end
                S_EMIT_CUR: begin
                    if (!pk_busy && !req.valid) begin
                        req <= '{valid: 1'b1, flush: 1'b0, last: 1'b0, tail: 1'b0,
                                 code: r_prefix};
                        r_state <= S_EMIT_CLR;
                    end
                end
                S_EMIT_CLR: begin
                    if (!pk_busy && !req.valid) begin
                        req <= '{valid: 1'b1, flush: 1'b0, last: 1'b1, tail: 1'b0,
                                 code: 16'(TABLE_ENTRIES)};
                        r_pvalid <= 1'b0; r_prefix <= '0;
                        r_count <= CW'(FIRST_CODE);
                        r_state <= S_IDLE;
                    end
                end
                S_END_CODE: begin
                    if (!pk_busy && !req.valid) begin
                        if (r_pvalid) begin
                            req <= '{valid: 1'b1, flush: 1'b0, last: 1'b1, tail: 1'b1,
                                     code: r_prefix};
                        end
                        r_state <= S_END_FLUSH;
                    end
                end
                S_END_FLUSH: begin
                    if (!pk_busy && !req.valid) begin
                        if (pk_pending) begin
                            req <= '{valid: 1'b1, flush: 1'b1, last: 1'b1, tail: 1'b0,
                                     code: '0};
                        end
                        r_pvalid <= 1'b0; r_prefix <= '0;
                        r_count <= CW'(FIRST_CODE);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lzw_packer #(.CODE_BITS(CODE_BITS)) u_packer (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_busy(pk_busy),
        .o_pending(pk_pending), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    `LZW_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count >= CW'(FIRST_CODE) && r_count <= TE)
    `LZW_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE && !pk_busy)
    `LZW_ASSERT_NXT(a_req_pulse, i_clk, i_rst_n, req.valid, !req.valid)
endmodule

// ===== rtl/core/lzw_packer.sv =====
// Bit packer: splits codes into LSB-first bytes and keeps the partial byte.
`include "lzw_compressor_12bit_assert.svh"
module lzw_packer #(
    parameter int unsigned CODE_BITS = lzw_pkg::CODE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzw_pkg::t_pack_req i_req,
    output logic               o_busy,
    output logic               o_pending,
    output logic               o_valid,
    input  logic               i_ready,
    output lzw_pkg::t_out_item o_item
);
    import lzw_pkg::*;

    localparam int unsigned AW = CODE_BITS + 8;

    logic [AW-1:0] r_acc, n_acc;
    logic [4:0]    r_total, n_total;
    logic          r_last, n_last;
    logic          r_tail, n_tail;
    logic          r_flush, n_flush;
    logic          r_active, n_active;
    logic [7:0]    r_buf, n_buf;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_oitem, n_oitem;

    assign o_busy    = r_active;
    assign o_pending = (r_cnt != 3'd0);
    assign o_valid   = r_ovalid;
    assign o_item    = r_oitem;

    always_comb begin
        n_acc = r_acc; n_total = r_total; n_last = r_last; n_flush = r_flush;
        n_tail = r_tail;
        n_active = r_active; n_buf = r_buf; n_cnt = r_cnt;
        n_ovalid = r_ovalid; n_oitem = r_oitem;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (i_req.valid && !r_active) begin
            n_active = 1'b1;
            n_last   = i_req.last;
            n_tail   = i_req.tail;
            n_flush  = i_req.flush;
            if (i_req.flush) begin
                n_acc   = AW'(r_buf);
                n_total = 5'd8;
            end else begin
                n_acc   = AW'(r_buf) | (AW'(i_req.code[CODE_BITS-1:0]) << r_cnt);
                n_total = 5'(r_cnt) + 5'(CODE_BITS);
            end
        end else if (r_active && !n_ovalid) begin
            n_ovalid         = 1'b1;
            n_oitem.out_byte = r_acc[7:0];
            n_acc            = r_acc >> 8;
            n_total          = r_total - 5'd8;
            // The final code of a stream is not last when a partial byte still follows.
            n_oitem.last_of_run = r_last && (n_total < 5'd8) &&
                                  (r_flush || !r_tail || n_total == 5'd0);
            if (n_total < 5'd8) begin
                n_active = 1'b0;
                n_buf    = r_flush ? 8'd0 : n_acc[7:0];
                n_cnt    = r_flush ? 3'd0 : n_total[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0; r_ovalid <= 1'b0; r_buf <= 8'd0; r_cnt <= 3'd0;
        end else begin
            r_active <= n_active; r_ovalid <= n_ovalid; r_buf <= n_buf; r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_total <= n_total; r_last <= n_last; r_flush <= n_flush;
        r_tail <= n_tail;
        r_oitem <= n_oitem;
    end

    `LZW_ASSERT_IMP(a_no_req_busy, i_clk, i_rst_n, r_active, !i_req.valid)
    `LZW_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid && $stable(r_oitem))
    `LZW_ASSERT_IMP(a_total_range, i_clk, i_rst_n, r_active, r_total >= 5'd8)
endmodule
